// ===== rtl/s512pad_pkg.sv =====
// Shared types, constants and helpers of the SHA-512 message padder.
package s512pad_pkg;

   // Block offset at which the 128-bit length field starts.
   localparam logic [6:0] LEN_OFFSET  = 7'd112;
   // Marker byte appended straight after the last message byte.
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   // Word indexes that carry the upper and lower halves of the 64-bit bit length.
   localparam logic [4:0] LEN_HI_WORD = 5'd30;
   localparam logic [4:0] LAST_WORD   = 5'd31;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic emit_flush;
      logic cfg_write;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic flush_last;
   } dp_sts_type;

   // Reverses the byte order of a 32-bit word.
   function automatic logic [31:0] byte_swap(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

// ===== rtl/s512pad_ctrl.sv =====
// Controller state machine of the SHA-512 message padder.
module s512pad_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_message_end,
   input  logic                       csr_valid,
   input  s512pad_pkg::dp_sts_type    dp_sts,
   output logic                       req_stall,
   output logic                       csr_ready,
   output logic                       busy,
   output s512pad_pkg::ctrl_cmd_type  ctrl_cmd
);
   import s512pad_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_FLUSH = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // A request is taken only when idle and the output register can take a word.
   assign req_stall = (state_ff != ST_IDLE) || !dp_sts.out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);
   assign busy      = (state_ff == ST_FLUSH);

   // Commands to the datapath.
   assign ctrl_cmd.load_item  = accept;
   assign ctrl_cmd.emit_flush = (state_ff == ST_FLUSH) && dp_sts.out_free;
   assign ctrl_cmd.cfg_write  = csr_valid && csr_ready;

   // Next state: a request that ends the message starts the padding flush.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_message_end) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (dp_sts.out_free && dp_sts.flush_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/s512pad_datapath.sv =====
// Datapath of the SHA-512 message padder: byte packing, padding words and output register.
module s512pad_datapath #(
   parameter int COUNT_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  s512pad_pkg::ctrl_cmd_type  ctrl_cmd,
   output s512pad_pkg::dp_sts_type    dp_sts,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_byte_present,
   input  logic                       req_message_end,
   input  logic                       csr_word_byte_order,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [31:0]                rsp_block_word,
   output logic [4:0]                 rsp_word_index,
   output logic                       rsp_first_block,
   output logic                       rsp_final_block,
   output logic                       rsp_run_last
);
   import s512pad_pkg::*;

   // Message state.
   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [23:0]           partial_ff, partial_in;
   logic                  in_first_ff, in_first_in;
   logic                  order_ff, order_in;

   // Flush cursor: offset of the marker byte, block within the flush, word index.
   logic [6:0]            mark_ff, mark_in;
   logic                  blk_ff, blk_in;
   logic [4:0]            widx_ff, widx_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_word_ff, rsp_word_in;
   logic [4:0]            rsp_index_ff, rsp_index_in;
   logic                  rsp_first_ff, rsp_first_in;
   logic                  rsp_final_ff, rsp_final_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Working signals.
   logic [6:0]            pos;
   logic [31:0]           acc;
   logic [COUNT_BITS-1:0] count_next;
   logic                  byte_word_done;
   logic [63:0]           len64;
   logic                  at_pad_word;
   logic                  in_final;
   logic [31:0]           flush_le;
   logic                  flush_final;
   logic                  flush_last;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_word  = rsp_word_ff;
   assign rsp_word_index  = rsp_index_ff;
   assign rsp_first_block = rsp_first_ff;
   assign rsp_final_block = rsp_final_ff;
   assign rsp_run_last    = rsp_last_ff;

   assign dp_sts.out_free   = !rsp_valid_ff || !rsp_stall;
   assign dp_sts.flush_last = flush_last;

   // Place the incoming byte into its lane of the pending word.
   always_comb begin
      pos        = byte_count_ff[6:0];
      acc        = {8'd0, partial_ff};
      count_next = byte_count_ff;
      if (req_byte_present) begin
         acc        = acc | (32'(req_data_byte) << {pos[1:0], 3'b000});
         count_next = byte_count_ff + COUNT_BITS'(1);
      end
      byte_word_done = req_byte_present && (pos[1:0] == 2'd3);
   end

   // Build the current padding word in first-byte-low order.
   always_comb begin
      len64       = 64'(byte_count_ff) << 3;
      at_pad_word = !blk_ff && (widx_ff == mark_ff[6:2]);
      in_final    = blk_ff || (mark_ff < LEN_OFFSET);
      flush_le    = '0;
      if (at_pad_word) begin
         flush_le = {8'd0, partial_ff} | (32'(PAD_BYTE) << {mark_ff[1:0], 3'b000});
      end
      if (in_final && (widx_ff == LEN_HI_WORD)) flush_le = flush_le | byte_swap(len64[63:32]);
      if (in_final && (widx_ff == LAST_WORD))   flush_le = flush_le | byte_swap(len64[31:0]);
      // A word completed by the marker byte itself is reported as not final.
      flush_final = in_final && !(at_pad_word && (mark_ff[1:0] == 2'd3));
      flush_last  = in_final && (widx_ff == LAST_WORD);
   end

   // Next-state logic for message state, flush cursor and output register.
   always_comb begin
      byte_count_in = byte_count_ff;
      partial_in    = partial_ff;
      in_first_in   = in_first_ff;
      order_in      = order_ff;
      mark_in       = mark_ff;
      blk_in        = blk_ff;
      widx_in       = widx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_final_in  = rsp_final_ff;
      rsp_last_in   = rsp_last_ff;

      if (ctrl_cmd.load_item) begin
         byte_count_in = count_next;
         partial_in    = byte_word_done ? 24'd0 : acc[23:0];
         if (byte_word_done) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = order_ff ? byte_swap(acc) : acc;
            rsp_index_in = pos[6:2];
            rsp_first_in = in_first_ff;
            rsp_final_in = 1'b0;
            rsp_last_in  = !req_message_end;
            if (pos[6:2] == LAST_WORD) in_first_in = 1'b0;
         end
         if (req_message_end) begin
            mark_in = count_next[6:0];
            blk_in  = 1'b0;
            widx_in = count_next[6:2];
         end
      end

      if (ctrl_cmd.emit_flush) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = order_ff ? byte_swap(flush_le) : flush_le;
         rsp_index_in = widx_ff;
         rsp_first_in = in_first_ff;
         rsp_final_in = flush_final;
         rsp_last_in  = flush_last;
         widx_in      = widx_ff + 5'd1;
         if (widx_ff == LAST_WORD) begin
            blk_in      = 1'b1;
            in_first_in = 1'b0;
         end
         // The last length word closes the message and readies the next one.
         if (flush_last) begin
            byte_count_in = '0;
            partial_in    = 24'd0;
            in_first_in   = 1'b1;
         end
      end

      if (ctrl_cmd.cfg_write) order_in = csr_word_byte_order;
   end

   // Control and message state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         partial_ff    <= 24'd0;
         in_first_ff   <= 1'b1;
         order_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         partial_ff    <= partial_in;
         in_first_ff   <= in_first_in;
         order_ff      <= order_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and flush cursor registers.
   always_ff @(posedge clock) begin
      mark_ff      <= mark_in;
      blk_ff       <= blk_in;
      widx_ff      <= widx_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_first_ff <= rsp_first_in;
      rsp_final_ff <= rsp_final_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

// ===== rtl/sha512_message_padder.sv =====
// Top level of the SHA-512 message padder.
//
// Takes a message one byte per request and returns the 32-bit words of its padded
// 128-byte SHA-512 blocks, each tagged with its word index and first/final block
// flags. A request carrying a byte yields a word whenever it completes four bytes;
// a bare request that neither carries a byte nor ends the message yields nothing.
// After a request that ends the message, the padding flush emits one word per cycle
// from the single output register while the output does not stall: 32 - m/4 words
// when the marker offset m is below 112, otherwise 64 - m/4 words, during which no
// request is taken. The configuration write sets the byte order within a word and
// is taken while idle.
module sha512_message_padder #(
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_block_word,
   output logic [4:0]  rsp_word_index,
   output logic        rsp_first_block,
   output logic        rsp_final_block,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_word_byte_order
);
   import s512pad_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_sts_type   dp_sts;
   logic         busy;

   // Controller.
   s512pad_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_message_end (req_message_end),
      .csr_valid       (csr_valid),
      .dp_sts          (dp_sts),
      .req_stall       (req_stall),
      .csr_ready       (csr_ready),
      .busy            (busy),
      .ctrl_cmd        (ctrl_cmd)
   );

   // Datapath.
   s512pad_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl_cmd            (ctrl_cmd),
      .dp_sts              (dp_sts),
      .req_data_byte       (req_data_byte),
      .req_byte_present    (req_byte_present),
      .req_message_end     (req_message_end),
      .csr_word_byte_order (csr_word_byte_order),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_block_word      (rsp_block_word),
      .rsp_word_index      (rsp_word_index),
      .rsp_first_block     (rsp_first_block),
      .rsp_final_block     (rsp_final_block),
      .rsp_run_last        (rsp_run_last)
   );

   // A request that ends the message always starts the flush.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_message_end) |=> busy)
      else $error("end of message did not start the padding flush");

   // The last word of the final block closes the run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_block && (rsp_word_index == LAST_WORD)) |-> rsp_run_last)
      else $error("final block word 31 not marked as run end");

   // Within the final block the run can only close on word 31.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_block && rsp_run_last) |-> (rsp_word_index == LAST_WORD))
      else $error("final block run closed before word 31");

endmodule
